### sv/apn_pkg.sv
// Shared constants, status codes and types for the absolute path normalizer.
// No dependencies; compiled first.
package apn_pkg;

    localparam int PATH_BYTES   = 256;
    localparam int MAX_PARTS    = 32;
    localparam int MAX_PART_LEN = 255;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 8;
    localparam int ST_W       = 3;
    localparam int PB_W       = $clog2(PATH_BYTES);
    localparam int WP_W       = $clog2(PATH_BYTES + 1);
    localparam int BANK_DEPTH = (PATH_BYTES + 1) / 2;
    localparam int BANK_AW    = PB_W - 1;
    localparam int PS_AW      = $clog2(MAX_PARTS);
    localparam int PC_W       = $clog2(MAX_PARTS + 1);
    localparam int TL_W       = $clog2(MAX_PART_LEN + 1);

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [ST_W-1:0] ST_ACCEPTED       = 3'd0;
    localparam logic [ST_W-1:0] ST_DONE_OK        = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_ABSOLUTE   = 3'd2;
    localparam logic [ST_W-1:0] ST_TOO_LONG       = 3'd3;
    localparam logic [ST_W-1:0] ST_PART_TOO_LONG  = 3'd4;
    localparam logic [ST_W-1:0] ST_TOO_MANY_PARTS = 3'd5;
    localparam logic [ST_W-1:0] ST_READ_DATA      = 3'd6;

    // one byte write into the result buffer
    typedef struct packed {
        logic              en;
        logic [PB_W-1:0]   addr;
        logic [BYTE_W-1:0] data;
    } buf_wr_t;

endpackage

### sv/apn_if.sv
// Valid/ready channel interfaces for the path normalizer: command and response.
// Depends on apn_pkg for field widths.
interface apn_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [apn_pkg::BYTE_W-1:0] path_byte;
    logic                       is_last;
    logic [apn_pkg::BYTE_W-1:0] read_index;

    modport source (output valid, action, path_byte, is_last, read_index, input ready);
    modport sink   (input valid, action, path_byte, is_last, read_index, output ready);
endinterface

interface apn_out_if;
    logic                       valid;
    logic                       ready;
    logic [apn_pkg::ST_W-1:0]   status;
    logic [apn_pkg::LEN_W-1:0]  result_length;
    logic [apn_pkg::BYTE_W-1:0] read_data;

    modport source (output valid, status, result_length, read_data, input ready);
    modport sink   (input valid, status, result_length, read_data, output ready);
endinterface

### sv/apn_rbuf.sv
// Result buffer: two byte banks split on address bit 0, so a separator and
// a character at consecutive positions land in the same cycle. Depends on apn_pkg.
module apn_rbuf (
    input  logic                       clk,
    input  apn_pkg::buf_wr_t           wr_a,
    input  apn_pkg::buf_wr_t           wr_b,
    input  logic                       rd_en,
    input  logic [apn_pkg::PB_W-1:0]   rd_addr,
    output logic [apn_pkg::BYTE_W-1:0] rd_data
);
    import apn_pkg::*;

    logic [BYTE_W-1:0] even_mem [BANK_DEPTH];
    logic [BYTE_W-1:0] odd_mem  [BANK_DEPTH];

    buf_wr_t           even_wr;
    buf_wr_t           odd_wr;
    logic [BYTE_W-1:0] even_q_reg;
    logic [BYTE_W-1:0] odd_q_reg;
    logic              sel_q_reg;

    // route each write to its bank; the two writes never share a bank
    always_comb
    begin
        even_wr = '0;
        odd_wr  = '0;
        if (wr_a.en && !wr_a.addr[0])
        begin
            even_wr = wr_a;
        end
        else if (wr_b.en && !wr_b.addr[0])
        begin
            even_wr = wr_b;
        end
        if (wr_a.en && wr_a.addr[0])
        begin
            odd_wr = wr_a;
        end
        else if (wr_b.en && wr_b.addr[0])
        begin
            odd_wr = wr_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (even_wr.en)
        begin
            even_mem[even_wr.addr[PB_W-1:1]] <= even_wr.data;
        end
        if (odd_wr.en)
        begin
            odd_mem[odd_wr.addr[PB_W-1:1]] <= odd_wr.data;
        end
        if (rd_en)
        begin
            even_q_reg <= even_mem[rd_addr[PB_W-1:1]];
            odd_q_reg  <= odd_mem[rd_addr[PB_W-1:1]];
            sel_q_reg  <= rd_addr[0];
        end
    end

    assign rd_data = sel_q_reg ? odd_q_reg : even_q_reg;

endmodule

### sv/absolute_path_normalizer.sv
// Absolute path normalizer: top level with the part-start stack and control.
// Depends on apn_pkg, apn_if (apn_in_if, apn_out_if) and apn_rbuf.
// A response beat is offered once its command beat has passed the stage 1 register
//   (for the registered memory read) and then the output register.
// Throughput: one command beat per cycle, push or read, while the response side does
//   not stall, set by the single write port of the part-start stack and the banked result buffer.
// Reset clears all control state; the stack and the result buffer are not cleared.
module absolute_path_normalizer (
    input  logic      clk,
    input  logic      rst_n,
    apn_in_if.sink    cmd,
    apn_out_if.source rsp
);
    import apn_pkg::*;

    // ------------------------------------------------------------------
    // Path state
    // ------------------------------------------------------------------
    logic [PC_W-1:0]   pc_reg,   pc_next;    // kept component count
    logic [WP_W-1:0]   wp_reg,   wp_next;    // buffer write pointer
    logic [PB_W-1:0]   ts_reg,   ts_next;    // start of current component
    logic [TL_W-1:0]   tl_reg,   tl_next;    // current component length
    logic [WP_W-1:0]   bs_reg,   bs_next;    // bytes seen, saturates
    logic [ST_W-1:0]   err_reg,  err_next;   // first error, sticky
    logic [PB_W-1:0]   fl_reg,   fl_next;    // final length of last path
    logic              dots_reg, dots_next;  // component is all dots so far
    logic [PB_W-1:0]   top_reg,  top_next;   // part_starts[pc-1], cached

    // part-start stack; read port prefetches entry pc-2 for a pop
    logic [PB_W-1:0]   ps_mem [MAX_PARTS];
    logic [PB_W-1:0]   ps_q_reg;
    logic              ps_we;
    logic [PS_AW-1:0]  ps_waddr;
    logic [PS_AW-1:0]  ps_raddr;

    // ------------------------------------------------------------------
    // Handshake and pipeline
    // ------------------------------------------------------------------
    logic              accept;
    logic              push_go;
    logic              push_last;
    logic              s1_adv;

    logic              s1_valid_reg;
    logic [ST_W-1:0]   s1_status_reg;
    logic [LEN_W-1:0]  s1_len_reg;
    logic              s1_hit_reg;

    logic              out_valid_reg;
    logic [ST_W-1:0]   out_status_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [BYTE_W-1:0] out_data_reg;

    // ------------------------------------------------------------------
    // Per-byte datapath
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] c;
    logic              take;
    logic              slash_we;
    logic              char_we;
    logic [WP_W-1:0]   wp_b;
    logic [WP_W-1:0]   wp_a;
    logic [PB_W-1:0]   ts_a;
    logic [TL_W-1:0]   tl_a;
    logic              dots_a;
    logic [ST_W-1:0]   err_a;
    logic [PC_W-1:0]   pc_a;
    logic              first_ok;
    logic [WP_W-1:0]   bs_inc;
    logic              close_req;
    logic [WP_W-1:0]   wp_f;
    logic [PC_W-1:0]   pc_f;
    logic [ST_W-1:0]   err_f;
    logic [TL_W-1:0]   tl_f;
    logic [PB_W-1:0]   top_f;
    logic              ps_push;
    logic [ST_W-1:0]   fin_status;

    logic [ST_W-1:0]   item_status;
    logic [LEN_W-1:0]  item_len;
    logic              item_hit;

    buf_wr_t           wr_a;
    buf_wr_t           wr_b;
    logic [BYTE_W-1:0] buf_q;

    assign c         = cmd.path_byte;
    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign cmd.ready = !s1_valid_reg || s1_adv;
    assign accept    = cmd.valid && cmd.ready;
    assign push_go   = accept && (cmd.action == ACT_PUSH);
    assign push_last = push_go && cmd.is_last;

    assign take   = (bs_reg < WP_W'(PATH_BYTES - 1)) && (err_reg == ST_ACCEPTED);
    assign bs_inc = (bs_reg < WP_W'(PATH_BYTES)) ? bs_reg + 1'b1 : bs_reg;

    // byte intake: leading slash, separator insert, component character
    always_comb
    begin
        wp_b     = wp_reg;
        wp_a     = wp_reg;
        ts_a     = ts_reg;
        tl_a     = tl_reg;
        dots_a   = dots_reg;
        err_a    = err_reg;
        pc_a     = pc_reg;
        first_ok = 1'b0;
        slash_we = 1'b0;
        char_we  = 1'b0;
        if (take)
        begin
            if (bs_reg == '0)
            begin
                if (c != CH_SLASH)
                begin
                    err_a = ST_NOT_ABSOLUTE;
                end
                else
                begin
                    first_ok = 1'b1;
                    wp_a     = WP_W'(1);
                    pc_a     = '0;
                    tl_a     = '0;
                end
            end
            else if (c != CH_SLASH)
            begin
                if (tl_reg == '0)
                begin
                    ts_a   = wp_reg[PB_W-1:0];
                    dots_a = 1'b1;
                    if (wp_reg > WP_W'(1) && wp_reg < WP_W'(PATH_BYTES))
                    begin
                        slash_we = 1'b1;
                        wp_b     = wp_reg + 1'b1;
                    end
                end
                wp_a = wp_b;
                if (tl_reg >= TL_W'(MAX_PART_LEN))
                begin
                    err_a = ST_PART_TOO_LONG;
                end
                else
                begin
                    if (wp_b < WP_W'(PATH_BYTES))
                    begin
                        char_we = 1'b1;
                        wp_a    = wp_b + 1'b1;
                    end
                    tl_a = tl_reg + 1'b1;
                    if (c != CH_DOT)
                    begin
                        dots_a = 1'b0;
                    end
                end
            end
        end
    end

    // component close: on a separator, or at the last byte with a token open
    assign close_req = (take && (bs_reg != '0) && (c == CH_SLASH) && (tl_reg != '0))
                    || (cmd.is_last && (bs_inc < WP_W'(PATH_BYTES))
                        && (err_a == ST_ACCEPTED) && (tl_a != '0));

    always_comb
    begin
        wp_f    = wp_a;
        pc_f    = pc_a;
        err_f   = err_a;
        tl_f    = tl_a;
        top_f   = top_reg;
        ps_push = 1'b0;
        if (close_req)
        begin
            tl_f = '0;
            priority if (dots_a && tl_a == TL_W'(1))
            begin
                wp_f = WP_W'(ts_a);
            end
            else if (dots_a && tl_a == TL_W'(2))
            begin
                wp_f = WP_W'(ts_a);
                if (pc_a != '0)
                begin
                    pc_f  = pc_a - 1'b1;
                    wp_f  = WP_W'(top_reg);
                    top_f = ps_q_reg;
                end
            end
            else if (pc_a >= PC_W'(MAX_PARTS))
            begin
                err_f = ST_TOO_MANY_PARTS;
            end
            else
            begin
                ps_push = 1'b1;
                pc_f    = pc_a + 1'b1;
                top_f   = ts_a;
            end
        end
    end

    always_comb
    begin
        priority if (bs_inc >= WP_W'(PATH_BYTES))
        begin
            fin_status = ST_TOO_LONG;
        end
        else if (err_f != ST_ACCEPTED)
        begin
            fin_status = err_f;
        end
        else
        begin
            fin_status = ST_DONE_OK;
        end
    end

    // next state: hold unless a push beat is taken; last beat rearms
    always_comb
    begin
        pc_next   = pc_reg;
        wp_next   = wp_reg;
        ts_next   = ts_reg;
        tl_next   = tl_reg;
        bs_next   = bs_reg;
        err_next  = err_reg;
        fl_next   = fl_reg;
        dots_next = dots_reg;
        top_next  = top_reg;
        if (push_go)
        begin
            top_next = top_f;
            if (cmd.is_last)
            begin
                pc_next   = '0;
                wp_next   = '0;
                ts_next   = '0;
                tl_next   = '0;
                bs_next   = '0;
                err_next  = ST_ACCEPTED;
                dots_next = 1'b0;
                fl_next   = (fin_status == ST_DONE_OK) ? wp_f[PB_W-1:0] : '0;
            end
            else
            begin
                pc_next   = pc_f;
                wp_next   = wp_f;
                ts_next   = ts_a;
                tl_next   = tl_f;
                bs_next   = bs_inc;
                err_next  = err_f;
                dots_next = dots_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            wp_reg   <= '0;
            ts_reg   <= '0;
            tl_reg   <= '0;
            bs_reg   <= '0;
            err_reg  <= ST_ACCEPTED;
            fl_reg   <= '0;
            dots_reg <= 1'b0;
            top_reg  <= '0;
        end
        else
        begin
            pc_reg   <= pc_next;
            wp_reg   <= wp_next;
            ts_reg   <= ts_next;
            tl_reg   <= tl_next;
            bs_reg   <= bs_next;
            err_reg  <= err_next;
            fl_reg   <= fl_next;
            dots_reg <= dots_next;
            top_reg  <= top_next;
        end
    end

    // ------------------------------------------------------------------
    // Part-start stack. The top entry lives in top_reg; the read port
    // always holds entry pc-2 so a ".." can refill top_reg at once.
    // Push writes entry pc while the read moves to pc-1: no overlap.
    // ------------------------------------------------------------------
    assign ps_we    = push_go && ps_push;
    assign ps_waddr = pc_a[PS_AW-1:0];
    assign ps_raddr = PS_AW'(pc_next - PC_W'(2));

    always_ff @(posedge clk)
    begin
        if (ps_we)
        begin
            ps_mem[ps_waddr] <= ts_a;
        end
        if (accept)
        begin
            ps_q_reg <= ps_mem[ps_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: leading slash or separator on port a, character on b
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_a = '0;
        wr_b = '0;
        if (push_go && first_ok)
        begin
            wr_a.en   = 1'b1;
            wr_a.addr = '0;
            wr_a.data = CH_SLASH;
        end
        else if (push_go && slash_we)
        begin
            wr_a.en   = 1'b1;
            wr_a.addr = wp_reg[PB_W-1:0];
            wr_a.data = CH_SLASH;
        end
        if (push_go && char_we)
        begin
            wr_b.en   = 1'b1;
            wr_b.addr = wp_b[PB_W-1:0];
            wr_b.data = c;
        end
    end

    apn_rbuf u_rbuf (
        .clk     (clk),
        .wr_a    (wr_a),
        .wr_b    (wr_b),
        .rd_en   (accept && (cmd.action == ACT_READ)),
        .rd_addr (PB_W'(cmd.read_index)),
        .rd_data (buf_q)
    );

    // ------------------------------------------------------------------
    // Response of the current beat
    // ------------------------------------------------------------------
    always_comb
    begin
        item_status = ST_ACCEPTED;
        item_len    = '0;
        item_hit    = 1'b0;
        if (cmd.action == ACT_READ)
        begin
            item_status = ST_READ_DATA;
            item_len    = LEN_W'(fl_reg);
            item_hit    = (bs_reg == '0) && (WP_W'(cmd.read_index) < WP_W'(fl_reg));
        end
        else if (cmd.is_last)
        begin
            item_status = fin_status;
            item_len    = (fin_status == ST_DONE_OK) ? LEN_W'(wp_f) : '0;
        end
    end

    // stage 1 waits on the buffer read, then the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= item_status;
            s1_len_reg    <= item_len;
            s1_hit_reg    <= item_hit;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_len_reg    <= s1_len_reg;
            out_data_reg   <= s1_hit_reg ? buf_q : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.result_length = out_len_reg;
    assign rsp.read_data     = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_W'(MAX_PARTS))
        else $error("part count past stack depth");

    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_a.en && wr_b.en) |-> (wr_a.addr[0] != wr_b.addr[0]))
        else $error("two buffer writes hit one bank");

    a_stack_port: assert property (@(posedge clk) disable iff (!rst_n)
        (ps_we && !push_last) |-> (ps_raddr != ps_waddr))
        else $error("stack prefetch overlaps a push");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        push_last |=> (bs_reg == '0 && pc_reg == '0 && err_reg == ST_ACCEPTED))
        else $error("path state not rearmed after last byte");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_status_reg)))
        else $error("stalled beat lost in stage 1");

endmodule

### bench/absolute_path_normalizer_tb.sv
// Self-checking bench for absolute_path_normalizer: directed and random path beats,
// checked against an in-bench model of the canonical path builder.
// Depends on apn_pkg, apn_if (apn_in_if, apn_out_if) and the RTL under sv/.
module absolute_path_normalizer_tb;
    import apn_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_BEATS = 820;   // stop filling once this many random beats are queued
    localparam int DRAIN_CYCLES = 8;     // margin to catch a stray late response
    localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either channel

    // error register value meaning "no error yet"
    localparam logic [ST_W-1:0] NO_ERROR = ST_ACCEPTED;

    typedef struct {
        logic              action;
        logic [BYTE_W-1:0] path_byte;
        logic              is_last;
        logic [BYTE_W-1:0] read_index;
        bit                hold_for_idle;  // sender waits until nothing is outstanding
    } path_cmd_t;

    typedef struct {
        logic [ST_W-1:0]   status;
        logic [LEN_W-1:0]  result_length;
        logic [BYTE_W-1:0] read_data;
    } path_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    apn_in_if  cmd_bus ();
    apn_out_if rsp_bus ();

    absolute_path_normalizer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Canonical path model state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] canon_buf [PATH_BYTES];   // result bytes, written as the path streams in
    logic [WP_W-1:0]   comp_start [MAX_PARTS];   // buffer position of each kept component
    logic [PC_W-1:0]   comp_depth = '0;
    logic [WP_W-1:0]   wr_ptr     = '0;
    logic [WP_W-1:0]   tok_start  = '0;
    logic [TL_W-1:0]   tok_len    = '0;
    logic [WP_W-1:0]   bytes_in   = '0;          // saturates at PATH_BYTES
    logic [ST_W-1:0]   err_code   = NO_ERROR;
    logic [LEN_W-1:0]  canon_len  = '0;          // length of the last finished path
    bit                tok_dots   = 1'b0;        // current component is dots only

    path_cmd_t path_cmds [$];    // beats waiting to be sent
    path_rsp_t replies_due [$];  // predicted responses, oldest first

    path_cmd_t   next_cmd;
    path_rsp_t   want_rsp;
    int unsigned stim_count = 0;
    int unsigned beats_in   = 0;
    int unsigned beats_out  = 0;
    int unsigned fail_count = 0;
    int unsigned send_gap   = 0;
    int unsigned send_calm  = 0;
    int unsigned stall_left = 0;
    int unsigned stall_len  = 0;
    int unsigned recv_calm  = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("ERROR: %s", msg);
    endtask

    // Idle length for either side: mostly none, some short, a few long.
    // Now and then a calm stretch with no idling at all.
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        roll = $urandom_range(0, 999);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if (roll < 15)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 600)
            return 0;
        if (roll < 900)
            return $urandom_range(1, 3);
        if (roll < 980)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void put_char(input logic [BYTE_W-1:0] ch);
        if (wr_ptr < PATH_BYTES)
        begin
            canon_buf[wr_ptr[PB_W-1:0]] = ch;
            wr_ptr++;
        end
    endfunction

    // End of a component: "." rewinds to its own start, ".." also drops the
    // component below it, anything else is kept on the stack unless it is full (too many parts).
    function automatic void close_component();
        if (tok_dots && tok_len == 1)
            wr_ptr = tok_start;
        else if (tok_dots && tok_len == 2)
        begin
            wr_ptr = tok_start;
            if (comp_depth != 0)
            begin
                comp_depth--;
                wr_ptr = comp_start[comp_depth[PS_AW-1:0]];
            end
        end
        else if (comp_depth >= MAX_PARTS)
            err_code = ST_TOO_MANY_PARTS;
        else
        begin
            comp_start[comp_depth[PS_AW-1:0]] = tok_start;
            comp_depth++;
        end
        tok_len = '0;
    endfunction

    function automatic void take_char(input logic [BYTE_W-1:0] ch);
        if (bytes_in == 0)
        begin
            if (ch != CH_SLASH)
            begin
                err_code = ST_NOT_ABSOLUTE;
                return;
            end
            wr_ptr = '0;
            put_char(CH_SLASH);
            comp_depth = '0;
            tok_len    = '0;
            return;
        end
        if (ch == CH_SLASH)
        begin
            if (tok_len != 0)
                close_component();
            return;
        end
        if (tok_len == 0)
        begin
            tok_start = wr_ptr;
            tok_dots  = 1'b1;
            if (wr_ptr > 1)
                put_char(CH_SLASH);
        end
        if (tok_len >= MAX_PART_LEN)
        begin
            err_code = ST_PART_TOO_LONG;
            return;
        end
        put_char(ch);
        tok_len++;
        if (ch != CH_DOT)
            tok_dots = 1'b0;
    endfunction

    // One response per command beat.
    function automatic path_rsp_t normalizer_reply(input path_cmd_t c);
        path_rsp_t r;
        r.status        = ST_ACCEPTED;
        r.result_length = '0;
        r.read_data     = '0;
        if (c.action == ACT_READ)
        begin
            r.status        = ST_READ_DATA;
            r.result_length = canon_len;
            // reads mid-path and past the end return zero
            if (bytes_in == 0 && c.read_index < canon_len)
                r.read_data = canon_buf[c.read_index];
        end
        else
        begin
            if (bytes_in < PATH_BYTES - 1 && err_code == NO_ERROR)
                take_char(c.path_byte);
            if (bytes_in < PATH_BYTES)
                bytes_in++;
            if (c.is_last)
            begin
                if (bytes_in < PATH_BYTES && err_code == NO_ERROR && tok_len != 0)
                    close_component();
                // too long beats every other error
                if (bytes_in >= PATH_BYTES)
                    r.status = ST_TOO_LONG;
                else if (err_code != NO_ERROR)
                    r.status = err_code;
                else
                    r.status = ST_DONE_OK;
                canon_len       = (r.status == ST_DONE_OK) ? wr_ptr[LEN_W-1:0] : '0;
                r.result_length = canon_len;
                bytes_in   = '0;
                comp_depth = '0;
                tok_len    = '0;
                tok_start  = '0;
                err_code   = NO_ERROR;
                wr_ptr     = '0;
                tok_dots   = 1'b0;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_cmd(input logic act, input logic [BYTE_W-1:0] ch, input logic fin,
                           input logic [BYTE_W-1:0] idx, input bit hold);
        path_cmd_t c;
        c.action        = act;
        c.path_byte     = ch;
        c.is_last       = fin;
        c.read_index    = idx;
        c.hold_for_idle = hold;
        path_cmds.push_back(c);
        stim_count++;
    endtask

    // Unused payload fields get random values so every bit toggles.
    task automatic add_read(input logic [BYTE_W-1:0] idx);
        add_cmd(ACT_READ, BYTE_W'($urandom), 1'($urandom), idx, 1'b0);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_cmd(ACT_PUSH, s[i], i == s.len() - 1, BYTE_W'($urandom), 1'b0);
    endtask

    // Appends separator run plus one component; pop_pct sets how often it is "..".
    task automatic append_component(ref logic [BYTE_W-1:0] bq [$], input int unsigned pop_pct);
        int unsigned roll;
        logic [BYTE_W-1:0] ch;
        repeat ($urandom_range(1, 3)) bq.push_back(CH_SLASH);
        roll = $urandom_range(0, 99);
        if (roll < pop_pct)
        begin
            bq.push_back(CH_DOT);
            bq.push_back(CH_DOT);
        end
        else if (roll < pop_pct + 15)
            bq.push_back(CH_DOT);
        else if (roll < pop_pct + 20)
            repeat (3) bq.push_back(CH_DOT);
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                // mostly printable names, sometimes any nonzero byte
                do
                    ch = BYTE_W'(($urandom_range(0, 99) < 85) ? $urandom_range(8'h21, 8'h7e)
                                                              : $urandom_range(1, 255));
                while (ch == CH_SLASH);
                bq.push_back(ch);
            end
        end
    endtask

    // Sends one path, with an occasional read slipped in mid-path,
    // then a few reads of the result around its length.
    task automatic queue_path(input logic [BYTE_W-1:0] bq [$], input bit hold);
        for (int i = 0; i < bq.size(); i++)
        begin
            if (i != 0 && $urandom_range(0, 99) < 4)
                add_read(BYTE_W'($urandom_range(0, 255)));
            add_cmd(ACT_PUSH, bq[i], i == bq.size() - 1, BYTE_W'($urandom), hold && i == 0);
        end
        repeat ($urandom_range(0, 5))
            add_read(BYTE_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, bq.size())
                                                          : $urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Command driver: one beat per handshake, random gaps after each beat.
    // A beat flagged hold_for_idle waits until every response is back.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid      <= 1'b0;
            cmd_bus.action     <= ACT_PUSH;
            cmd_bus.path_byte  <= '0;
            cmd_bus.is_last    <= 1'b0;
            cmd_bus.read_index <= '0;
        end
        else if (!cmd_bus.valid || cmd_bus.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                cmd_bus.valid <= 1'b0;
            end
            else if (path_cmds.size() != 0 &&
                     !(path_cmds[0].hold_for_idle &&
                       (replies_due.size() != 0 || cmd_bus.valid)))
            begin
                next_cmd = path_cmds.pop_front();
                cmd_bus.action     <= next_cmd.action;
                cmd_bus.path_byte  <= next_cmd.path_byte;
                cmd_bus.is_last    <= next_cmd.is_last;
                cmd_bus.read_index <= next_cmd.read_index;
                cmd_bus.valid      <= 1'b1;
                send_gap = pick_gap(send_calm);
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    // Response ready with random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            stall_len = pick_gap(recv_calm);
            rsp_bus.ready <= (stall_len == 0);
            if (stall_len != 0)
                stall_left = stall_len - 1;
        end
    end

    // Command monitor: every accepted beat runs through the predictor.
    always @(posedge clk)
    begin
        if (rst_n && cmd_bus.valid && cmd_bus.ready)
        begin
            beats_in++;
            next_cmd.action        = cmd_bus.action;
            next_cmd.path_byte     = cmd_bus.path_byte;
            next_cmd.is_last       = cmd_bus.is_last;
            next_cmd.read_index    = cmd_bus.read_index;
            next_cmd.hold_for_idle = 1'b0;
            replies_due.push_back(normalizer_reply(next_cmd));
        end
    end

    // Response monitor: compare each accepted beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            beats_out++;
            if (replies_due.size() == 0)
                report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                          beats_out));
            else
            begin
                want_rsp = replies_due.pop_front();
                if (rsp_bus.status !== want_rsp.status)
                    report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                              beats_out, rsp_bus.status, want_rsp.status));
                if (rsp_bus.result_length !== want_rsp.result_length)
                    report_mismatch($sformatf("response %0d length %0d, expected %0d",
                                              beats_out, rsp_bus.result_length,
                                              want_rsp.result_length));
                if (rsp_bus.read_data !== want_rsp.read_data)
                    report_mismatch($sformatf("response %0d read_data 0x%02h, expected 0x%02h",
                                              beats_out, rsp_bus.read_data,
                                              want_rsp.read_data));
            end
        end
    end

    // Watchdog: no beat on either channel for too long ends the run.
    initial
    begin : watchdog
        int unsigned quiet;
        int unsigned seen_beats;
        quiet      = 0;
        seen_beats = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (beats_in + beats_out != seen_beats)
            begin
                seen_beats = beats_in + beats_out;
                quiet      = 0;
            end
            else
                quiet++;
        end
        report_mismatch($sformatf("timeout: %0d beats unsent, %0d responses outstanding",
                                  path_cmds.size(), replies_due.size()));
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [BYTE_W-1:0] bq [$];
        logic [BYTE_W-1:0] ch;
        int unsigned       roll;
        int unsigned       path_no;
        int unsigned       long_len;

        rst_n = 1'b0;

        // Directed part
        add_read(8'd0);                 // nothing normalized yet: zero data, zero length
        queue_text("/");                // root alone
        add_read(8'd0);
        queue_text("//a/./../b//");     // slash runs, dot, dot-dot, trailing slash -> "/b"
        add_read(8'd1);
        queue_text("/..");              // dot-dot at the root stays at the root
        add_cmd(ACT_PUSH, 8'hff, 1'b1, 8'h00, 1'b0);  // not absolute, top byte value
        add_read(8'd0);                 // after a failed path every read is zero
        add_cmd(ACT_PUSH, CH_SLASH, 1'b0, 8'hff, 1'b0);
        add_read(8'd0);                 // read while a path is open
        add_cmd(ACT_PUSH, 8'h00, 1'b1, 8'h00, 1'b0);  // zero byte is a plain name char
        add_read(8'hff);                // far past the end

        // Random part: mostly well-formed paths, some deep stacks, some junk.
        // Two long paths straddle the buffer limit (255 fits, 256 is too long).
        stim_count = 0;
        path_no    = 0;
        while (stim_count < RANDOM_BEATS)
        begin
            bq.delete();
            roll = $urandom_range(0, 99);
            if (path_no == 2 || path_no == 5)
            begin
                long_len = (path_no == 2) ? PATH_BYTES - 1 : PATH_BYTES;
                bq.push_back(CH_SLASH);
                while (bq.size() < long_len)
                    append_component(bq, 45);
                while (bq.size() > long_len)
                    void'(bq.pop_back());
            end
            else if (roll < 70)
            begin
                bq.push_back(CH_SLASH);
                repeat ($urandom_range(0, 8)) append_component(bq, 20);
                if ($urandom_range(0, 3) == 0)
                    bq.push_back(CH_SLASH);
            end
            else if (roll < 78)
            begin
                // enough kept components to hit or just miss the stack limit
                bq.push_back(CH_SLASH);
                repeat ($urandom_range(MAX_PARTS, MAX_PARTS + 8)) append_component(bq, 0);
            end
            else if (roll < 88)
            begin
                do
                    ch = BYTE_W'($urandom_range(0, 255));
                while (ch == CH_SLASH);
                bq.push_back(ch);
                repeat ($urandom_range(0, 4)) append_component(bq, 20);
            end
            else
            begin
                // raw bytes, half of them rooted
                if ($urandom_range(0, 1) == 0)
                    bq.push_back(CH_SLASH);
                repeat ($urandom_range(1, 20)) bq.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            queue_path(bq, path_no == 0 || $urandom_range(0, 99) < 3);
            path_no++;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (path_cmds.size() != 0 || cmd_bus.valid)
            @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        // catch any stray response after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
sv/apn_pkg.sv
sv/apn_if.sv
sv/apn_rbuf.sv
sv/absolute_path_normalizer.sv
bench/absolute_path_normalizer_tb.sv
